>>> rtl/rbsi_pkg.sv
// shared constants and word types for the ray versus box slab test
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int MAG_W = DATA_W + 1 + FRAC_BITS;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
    logic signed [DATA_W-1:0] box_min_x;
    logic signed [DATA_W-1:0] box_min_y;
    logic signed [DATA_W-1:0] box_min_z;
    logic signed [DATA_W-1:0] box_max_x;
    logic signed [DATA_W-1:0] box_max_y;
    logic signed [DATA_W-1:0] box_max_z;
  } in_word_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] hit_distance;
    logic signed [DATA_W-1:0] hit_point_x;
    logic signed [DATA_W-1:0] hit_point_y;
    logic signed [DATA_W-1:0] hit_point_z;
    logic [2:0]               hit_face;
  } out_word_t;

  // per item data that rides alongside the dividers
  typedef struct packed {
    logic [2:0][DATA_W-1:0] org;
    logic [2:0][DATA_W-1:0] dir;
    logic [2:0]             ok;
    logic                   pmiss;
  } carry_t;

endpackage

>>> rtl/rbsi_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated signed result
module rbsi_div (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [rbsi_pkg::MAG_W-1:0]            num,
  input  logic [rbsi_pkg::DATA_W-1:0]           den,
  input  logic                                  neg,
  output logic signed [rbsi_pkg::DATA_W-1:0]    quo
);

  localparam int MW = rbsi_pkg::MAG_W;
  localparam int DW = rbsi_pkg::DATA_W;

  logic [DW-1:0] rem_r [MW];
  logic [MW-1:0] num_r [MW];
  logic [MW-1:0] q_r   [MW];
  logic [DW-1:0] den_r [MW];
  logic          neg_r [MW];

  logic [DW-1:0] rem_in [MW];
  logic [MW-1:0] num_in [MW];
  logic [MW-1:0] q_in   [MW];
  logic [DW-1:0] den_in [MW];
  logic          neg_in [MW];

  genvar i;
  generate
    for (i = 0; i < MW; i++) begin : g_stage
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;

      if (i == 0) begin : g_first
        assign rem_in[i] = '0;
        assign num_in[i] = num;
        assign q_in[i]   = '0;
        assign den_in[i] = den;
        assign neg_in[i] = neg;
      end else begin : g_next
        assign rem_in[i] = rem_r[i-1];
        assign num_in[i] = num_r[i-1];
        assign q_in[i]   = q_r[i-1];
        assign den_in[i] = den_r[i-1];
        assign neg_in[i] = neg_r[i-1];
      end

      assign trial = {rem_in[i], num_in[i][MW-1]};
      assign diff  = trial - {1'b0, den_in[i]};
      assign ge    = (trial >= {1'b0, den_in[i]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          num_r[i] <= {num_in[i][MW-2:0], 1'b0};
          q_r[i]   <= {q_in[i][MW-2:0], ge};
          den_r[i] <= den_in[i];
          neg_r[i] <= neg_in[i];
        end
      end
    end
  endgenerate

  logic [MW-1:0] qm;
  assign qm = q_r[MW-1];

  always_comb begin
    if (!neg_r[MW-1]) begin
      if (qm > MW'({1'b0, {(DW-1){1'b1}}})) quo = rbsi_pkg::S_MAX;
      else                                 quo = $signed(qm[DW-1:0]);
    end else begin
      if (qm > MW'({1'b1, {(DW-1){1'b0}}})) quo = rbsi_pkg::S_MIN;
      else                                 quo = $signed(-qm[DW-1:0]);
    end
  end

endmodule

>>> rtl/ray_box_slab_intersect.sv
// top level: ray versus axis-aligned box slab test, fully pipelined
// the input register a, the divider stages, stages b to e and the output register form the pipeline
// throughput: one word per cycle unless out_stall holds it; six dividers work one quotient bit per stage
// the whole pipeline holds while the output word waits on out_stall
// reset clears all valid bits; data registers are not reset
module ray_box_slab_intersect (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rbsi_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rbsi_pkg::out_word_t  out_word
);

  localparam int MW = rbsi_pkg::MAG_W;
  localparam int DW = rbsi_pkg::DATA_W;
  localparam int FB = rbsi_pkg::FRAC_BITS;

  logic en;
  logic out_valid_r;
  rbsi_pkg::out_word_t out_word_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // stage a: input register
  logic                a_valid_r;
  rbsi_pkg::in_word_t  a_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_word_r <= in_word;
    end
  end

  logic signed [DW-1:0] org [3];
  logic signed [DW-1:0] dir [3];
  logic signed [DW-1:0] bmin [3];
  logic signed [DW-1:0] bmax [3];

  assign org[0]  = a_word_r.origin_x;
  assign org[1]  = a_word_r.origin_y;
  assign org[2]  = a_word_r.origin_z;
  assign dir[0]  = a_word_r.dir_x;
  assign dir[1]  = a_word_r.dir_y;
  assign dir[2]  = a_word_r.dir_z;
  assign bmin[0] = a_word_r.box_min_x;
  assign bmin[1] = a_word_r.box_min_y;
  assign bmin[2] = a_word_r.box_min_z;
  assign bmax[0] = a_word_r.box_max_x;
  assign bmax[1] = a_word_r.box_max_y;
  assign bmax[2] = a_word_r.box_max_z;

  logic [MW-1:0]         dnum [6];
  logic [DW-1:0]         dden [6];
  logic                  dneg [6];
  logic signed [DW-1:0]  dquo [6];
  rbsi_pkg::carry_t      a_car;

  always_comb begin
    logic signed [DW:0] diff;
    logic [DW:0]        mag;
    logic signed [DW-1:0] bnd;
    a_car.pmiss = 1'b0;
    for (int f = 0; f < 6; f++) begin
      bnd = f[0] ? bmax[f/2] : bmin[f/2];
      diff = {bnd[DW-1], bnd} - {org[f/2][DW-1], org[f/2]};
      mag  = diff[DW] ? -diff : diff;
      dnum[f] = {mag, {FB{1'b0}}};
      dden[f] = dir[f/2][DW-1] ? -dir[f/2] : dir[f/2];
      dneg[f] = diff[DW] ^ dir[f/2][DW-1];
    end
    for (int a = 0; a < 3; a++) begin
      a_car.org[a] = org[a];
      a_car.dir[a] = dir[a];
      a_car.ok[a]  = (dir[a] != '0);
      if (dir[a] == '0 && (org[a] < bmin[a] || org[a] > bmax[a])) begin
        a_car.pmiss = 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < 6; g++) begin : g_div
      rbsi_div u_div (
        .clk (clk),
        .en  (en),
        .num (dnum[g]),
        .den (dden[g]),
        .neg (dneg[g]),
        .quo (dquo[g])
      );
    end
  endgenerate

  // valid and carry line alongside the divider stages
  logic             dv_r  [MW];
  rbsi_pkg::carry_t dc_r  [MW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MW; s++) dv_r[s] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= a_valid_r;
      for (int s = 1; s < MW; s++) dv_r[s] <= dv_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0] <= a_car;
      for (int s = 1; s < MW; s++) dc_r[s] <= dc_r[s-1];
    end
  end

  // stage b: slab distances
  logic                  b_valid_r;
  logic signed [DW-1:0]  b_ts_r [6];
  rbsi_pkg::carry_t      b_car_r;

  // stage c: entry and exit bounds
  logic                  c_valid_r;
  logic signed [DW-1:0]  c_ts_r [6];
  logic signed [DW-1:0]  c_tmin_r, c_tmin_nxt;
  logic signed [DW-1:0]  c_tmax_r, c_tmax_nxt;
  rbsi_pkg::carry_t      c_car_r;

  // stage d: hit decision
  logic                  d_valid_r;
  logic signed [DW-1:0]  d_ts_r [6];
  logic                  d_hit_r, d_hit_nxt;
  logic signed [DW-1:0]  d_t_r, d_t_nxt;
  rbsi_pkg::carry_t      d_car_r;

  // stage e: face and products
  logic                  e_valid_r;
  logic                  e_hit_r;
  logic signed [DW-1:0]  e_t_r;
  logic [2:0]            e_face_r, e_face_nxt;
  logic signed [2*DW-1:0] e_prod_r [3];
  rbsi_pkg::carry_t      e_car_r;

  always_comb begin
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    c_tmin_nxt = rbsi_pkg::S_MIN;
    c_tmax_nxt = rbsi_pkg::S_MAX;
    for (int a = 0; a < 3; a++) begin
      lo = (b_ts_r[2*a] < b_ts_r[2*a+1]) ? b_ts_r[2*a] : b_ts_r[2*a+1];
      hi = (b_ts_r[2*a] < b_ts_r[2*a+1]) ? b_ts_r[2*a+1] : b_ts_r[2*a];
      if (b_car_r.ok[a]) begin
        if (lo > c_tmin_nxt) c_tmin_nxt = lo;
        if (hi < c_tmax_nxt) c_tmax_nxt = hi;
      end
    end
  end

  always_comb begin
    d_hit_nxt = !(c_car_r.pmiss || c_tmax_r < 0 || c_tmin_r > c_tmax_r);
    d_t_nxt   = (c_tmin_r < 0) ? c_tmax_r : c_tmin_r;
  end

  always_comb begin
    e_face_nxt = 3'd0;
    for (int f = 0; f < 6; f++) begin
      if (d_car_r.ok[f/2] && d_ts_r[f] == d_t_r) e_face_nxt = 3'(f);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r   <= dv_r[MW-1];
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      e_valid_r   <= d_valid_r;
      out_valid_r <= e_valid_r;
    end
  end

  logic signed [2*DW-1:0] step [3];
  logic signed [2*DW-1:0] sum  [3];
  logic signed [DW-1:0]   pt   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      step[a] = e_prod_r[a] >>> FB;
      sum[a]  = {{DW{e_car_r.org[a][DW-1]}}, e_car_r.org[a]} + step[a];
      if (sum[a] > $signed({{DW{1'b0}}, rbsi_pkg::S_MAX})) begin
        pt[a] = rbsi_pkg::S_MAX;
      end else if (sum[a] < $signed({{DW{1'b1}}, rbsi_pkg::S_MIN})) begin
        pt[a] = rbsi_pkg::S_MIN;
      end else begin
        pt[a] = sum[a][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int f = 0; f < 6; f++) begin
        b_ts_r[f] <= dquo[f];
        c_ts_r[f] <= b_ts_r[f];
        d_ts_r[f] <= c_ts_r[f];
      end
      b_car_r  <= dc_r[MW-1];
      c_car_r  <= b_car_r;
      c_tmin_r <= c_tmin_nxt;
      c_tmax_r <= c_tmax_nxt;
      d_car_r  <= c_car_r;
      d_hit_r  <= d_hit_nxt;
      d_t_r    <= d_t_nxt;
      e_car_r  <= d_car_r;
      e_hit_r  <= d_hit_r;
      e_t_r    <= d_t_r;
      e_face_r <= e_face_nxt;
      for (int a = 0; a < 3; a++) begin
        e_prod_r[a] <= (2*DW)'(d_t_r) * (2*DW)'($signed(d_car_r.dir[a]));
      end
      if (e_hit_r) begin
        out_word_r.hit          <= 1'b1;
        out_word_r.hit_distance <= e_t_r;
        out_word_r.hit_point_x  <= pt[0];
        out_word_r.hit_point_y  <= pt[1];
        out_word_r.hit_point_z  <= pt[2];
        out_word_r.hit_face     <= e_face_r;
      end else begin
        out_word_r <= '0;
      end
    end
  end

endmodule
